>>> src/socwu_pkg.sv
`default_nettype none
package socwu_pkg;

  // section parts, in stream order
  typedef enum logic [1:0] {
    PH_BITMAP,
    PH_FIRST,
    PH_SECOND,
    PH_DONE
  } phase_t;

  // control sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BITS,
    ST_BMRD,
    ST_GRRD,
    ST_SUM,
    ST_SHIFT,
    ST_REF,
    ST_MUL,
    ST_RND,
    ST_FIN
  } state_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_VALUE_COUNT  = 3'd0,
    CFG_GROUP_COUNT  = 3'd1,
    CFG_FIRST_WIDTH  = 3'd2,
    CFG_GROUP_WIDTH  = 3'd3,
    CFG_BINARY_SCALE = 3'd4,
    CFG_REFERENCE    = 3'd5,
    CFG_DEC_MULT     = 3'd6
  } cfg_idx_t;

  // input operations
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_PULL = 1'b1;

  // fixed datapath widths
  localparam int VC_W   = 17;
  localparam int GC_W   = 13;
  localparam int WD_W   = 6;
  localparam int BS_W   = 7;
  localparam int REF_W  = 48;
  localparam int DM_W   = 33;
  localparam int SUM_W  = 33;
  localparam int SHL_W  = 112;
  localparam int SREF_W = 113;
  localparam int MAG_W  = 96;
  localparam int Q_W    = 97;
  localparam int FRAC_W = 32;
  localparam int OUT_W  = 64;

  localparam logic signed [7:0] E_BIAS = 8'sd16;
  localparam logic [MAG_W-1:0]  MAG_CLAMP = {1'b1, {(MAG_W-1){1'b0}}};
  localparam logic [OUT_W-1:0]  OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0]  OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [DM_W-1:0]   DM_ONE = {1'b1, {(DM_W-1){1'b0}}};

endpackage
`default_nettype wire

>>> src/socwu_ram.sv
`default_nettype none
module socwu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/second_order_constant_width_unpacker.sv
`default_nettype none
// Byte transaction: taken when idle, then one section bit per cycle, paused while a value
// is decoded; a section boundary ends the byte. A value takes 2 store reads, sum, shift,
// reference add, 32-step serial multiply, rounding, output load (no multiply or rounding
// when the multiplier is one or more). Pulls yield values in a zero-width second part only.
// rst_n is synchronous, active low: control state, out_valid and configuration are reset;
// payload registers and the bitmap and group value stores are not cleared.
module second_order_constant_width_unpacker #(
  parameter int MAX_VALUES = 65536,
  parameter int MAX_GROUPS = 4096,
  parameter int MAX_WIDTH  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [63:0] out_value_q16,
  output logic             out_last_in_field,
  output logic             out_last_in_run,
  output logic             out_index_error,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_wdata
);

  import socwu_pkg::*;

  localparam int VCW  = $clog2(MAX_VALUES + 1);
  localparam int GCW  = $clog2(MAX_GROUPS + 1);
  localparam int CNTW = (VCW > GCW) ? VCW : GCW;
  localparam int VAW  = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int GAW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int HW   = $clog2(MAX_WIDTH + 1);

  typedef struct packed {
    phase_t              phase;
    logic [CNTW-1:0]     cnt;
    logic [MAX_WIDTH-1:0] acc;
    logic [HW-1:0]       held;
    logic [CNTW-1:0]     cgp1;  // current group plus one
    logic [CNTW-1:0]     zf;    // first group index whose value is zero
  } sect_t;

  // configuration registers
  logic [VC_W-1:0]  value_count_r;
  logic [GC_W-1:0]  group_count_r;
  logic [WD_W-1:0]  first_width_r;
  logic [WD_W-1:0]  group_width_r;
  logic [BS_W-1:0]  binary_scale_r;
  logic [REF_W-1:0] reference_r;
  logic [DM_W-1:0]  dec_mult_r;

  // control and datapath registers
  state_t               state_r, state_nxt;
  sect_t                sect_r, sect_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic [2:0]           bidx_r, bidx_nxt;
  logic [CNTW-1:0]      job_cnt_r, job_cnt_nxt;
  logic [MAX_WIDTH-1:0] job_v_r, job_v_nxt;
  logic                 job_lif_r, job_lif_nxt;
  logic                 job_lir_r, job_lir_nxt;
  logic                 more_r, more_nxt;
  logic                 err_r, err_nxt;
  logic [CNTW-1:0]      idx_r, idx_nxt;
  logic [SUM_W-1:0]     s_r, s_nxt;
  logic [SHL_W-1:0]     a_r, a_nxt;
  logic [MAG_W-1:0]     m_r, m_nxt;
  logic                 neg_r, neg_nxt;
  logic [Q_W-1:0]       hp_r, hp_nxt;
  logic [FRAC_W-1:0]    lp_r, lp_nxt;
  logic [FRAC_W-1:0]    dmsh_r, dmsh_nxt;
  logic [4:0]           mcnt_r, mcnt_nxt;
  logic [Q_W-1:0]       q_r, q_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_value_r, out_value_nxt;
  logic                 out_lif_r, out_lif_nxt;
  logic                 out_lir_r, out_lir_nxt;
  logic                 out_err_r, out_err_nxt;

  // store ports
  logic                 bm_we;
  logic [0:0]           bm_rdata;
  logic                 gr_we;
  logic [MAX_WIDTH-1:0] gr_wdata;
  logic [MAX_WIDTH-1:0] gr_rdata;

  // derived configuration
  logic [CNTW-1:0] nv, ng;
  logic [WD_W-1:0] fow_c, gw_c;
  logic            fo_zero, gw_zero;
  logic [CNTW-1:0] cg_new;
  sect_t           s1;

  always_comb begin
    nv = (32'(value_count_r) > 32'(MAX_VALUES)) ? CNTW'(MAX_VALUES) : CNTW'(value_count_r);
    ng = (32'(group_count_r) > 32'(MAX_GROUPS)) ? CNTW'(MAX_GROUPS) : CNTW'(group_count_r);
    fow_c = (32'(first_width_r) > 32'(MAX_WIDTH)) ? WD_W'(MAX_WIDTH) : first_width_r;
    gw_c  = (32'(group_width_r) > 32'(MAX_WIDTH)) ? WD_W'(MAX_WIDTH) : group_width_r;
    fo_zero = (fow_c == '0);
    gw_zero = (gw_c == '0);
  end

  // move on past parts that are already complete
  function automatic sect_t settle(sect_t s, logic [CNTW-1:0] nvals, logic [CNTW-1:0] ngrps,
                                   logic fzero);
    sect_t r;
    r = s;
    if (r.phase == PH_BITMAP && r.cnt >= nvals) begin
      r.phase = PH_FIRST;
      r.cnt = '0;
      r.acc = '0;
      r.held = '0;
    end
    if (r.phase == PH_FIRST) begin
      if (fzero && r.cnt < ngrps) begin
        r.zf = r.cnt;
        r.cnt = ngrps;
      end
      if (r.cnt >= ngrps) begin
        r.phase = PH_SECOND;
        r.cnt = '0;
        r.acc = '0;
        r.held = '0;
        r.cgp1 = '0;
      end
    end
    if (r.phase == PH_SECOND && r.cnt >= nvals) begin
      r.phase = PH_DONE;
    end
    return r;
  endfunction

  assign s1 = settle(sect_r, nv, ng, fo_zero);
  assign cg_new = sect_r.cgp1 + CNTW'(bm_rdata);

  // bitmap store
  socwu_ram #(.WIDTH(1), .DEPTH(MAX_VALUES)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (s1.cnt[VAW-1:0]),
    .wdata (byte_r[7]),
    .raddr (job_cnt_r[VAW-1:0]),
    .rdata (bm_rdata)
  );

  // first-order group value store
  socwu_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_GROUPS)) u_groups (
    .clk   (clk),
    .we    (gr_we),
    .waddr (s1.cnt[GAW-1:0]),
    .wdata (gr_wdata),
    .raddr (GAW'(cg_new - CNTW'(1))),
    .rdata (gr_rdata)
  );

  // sequencer: next state and datapath
  always_comb begin
    sect_t                t;
    sect_t                s2;
    logic [MAX_WIDTH-1:0] acc_sh;
    logic [MAX_WIDTH-1:0] vmask;
    logic [HW-1:0]        held_inc;
    logic [WD_W-1:0]      w;
    logic                 emit;
    logic                 done;
    logic [MAX_WIDTH-1:0] gv;
    logic [7:0]           e;
    logic [6:0]           n;
    logic [63:0]          rnd;
    logic [SREF_W-1:0]    sa;
    logic [SREF_W-1:0]    mag;
    logic [Q_W-1:0]       psum;

    state_nxt     = state_r;
    sect_nxt      = sect_r;
    byte_nxt      = byte_r;
    bidx_nxt      = bidx_r;
    job_cnt_nxt   = job_cnt_r;
    job_v_nxt     = job_v_r;
    job_lif_nxt   = job_lif_r;
    job_lir_nxt   = job_lir_r;
    more_nxt      = more_r;
    err_nxt       = err_r;
    idx_nxt       = idx_r;
    s_nxt         = s_r;
    a_nxt         = a_r;
    m_nxt         = m_r;
    neg_nxt       = neg_r;
    hp_nxt        = hp_r;
    lp_nxt        = lp_r;
    dmsh_nxt      = dmsh_r;
    mcnt_nxt      = mcnt_r;
    q_nxt         = q_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_lif_nxt   = out_lif_r;
    out_lir_nxt   = out_lir_r;
    out_err_nxt   = out_err_r;
    in_ready      = 1'b0;
    bm_we         = 1'b0;
    gr_we         = 1'b0;
    t             = s1;
    s2            = s1;
    emit          = 1'b0;
    done          = 1'b0;
    acc_sh        = (s1.acc << 1) | MAX_WIDTH'(byte_r[7]);
    held_inc      = s1.held + HW'(1);
    w             = (s1.phase == PH_FIRST) ? fow_c : gw_c;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      vmask[i] = (i < int'(w));
    end
    gr_wdata      = acc_sh & vmask;
    gv            = (idx_r >= sect_r.zf) ? '0 : gr_rdata;
    e             = {binary_scale_r[BS_W-1], binary_scale_r} + E_BIAS;
    n             = 7'(8'd0 - e);
    rnd           = 64'(s_r) + (64'd1 << (n - 7'd1));
    sa            = {1'b0, a_r} + {{(SREF_W-REF_W){reference_r[REF_W-1]}}, reference_r};
    mag           = sa[SREF_W-1] ? (~sa + SREF_W'(1)) : sa;
    psum          = hp_r + (dmsh_r[0] ? {1'b0, m_r} : '0);

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_operation == OP_BYTE) begin
            byte_nxt  = in_data_byte;
            bidx_nxt  = 3'd7;
            state_nxt = ST_BITS;
          end else begin
            sect_nxt = s1;
            if (s1.phase == PH_SECOND && gw_zero) begin
              t.cnt       = s1.cnt + CNTW'(1);
              sect_nxt    = settle(t, nv, ng, fo_zero);
              job_cnt_nxt = s1.cnt;
              job_v_nxt   = '0;
              job_lif_nxt = (t.cnt >= nv);
              job_lir_nxt = 1'b1;
              more_nxt    = 1'b0;
              state_nxt   = ST_BMRD;
            end
          end
        end
      end
      ST_BITS: begin
        if (s1.phase == PH_DONE || (s1.phase == PH_SECOND && gw_zero)) begin
          sect_nxt  = s1;
          state_nxt = ST_IDLE;
        end else begin
          if (s1.phase == PH_BITMAP) begin
            bm_we = 1'b1;
            t.cnt = s1.cnt + CNTW'(1);
          end else if (7'(held_inc) >= 7'(w)) begin
            t.acc  = '0;
            t.held = '0;
            t.cnt  = s1.cnt + CNTW'(1);
            if (s1.phase == PH_FIRST) begin
              gr_we = 1'b1;
            end else begin
              emit = 1'b1;
            end
          end else begin
            t.acc  = acc_sh;
            t.held = held_inc;
          end
          s2        = settle(t, nv, ng, fo_zero);
          sect_nxt  = s2;
          byte_nxt  = byte_r << 1;
          bidx_nxt  = bidx_r - 3'd1;
          done      = (s2.phase != s1.phase) || (bidx_r == 3'd0);
          if (emit) begin
            job_cnt_nxt = s1.cnt;
            job_v_nxt   = gr_wdata;
            job_lif_nxt = (t.cnt >= nv);
            job_lir_nxt = (WD_W'(bidx_r) < gw_c) || (t.cnt >= nv);
            more_nxt    = !done;
            state_nxt   = ST_BMRD;
          end else if (done) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_BMRD: begin
        state_nxt = ST_GRRD;
      end
      ST_GRRD: begin
        sect_nxt.cgp1 = cg_new;
        err_nxt       = (cg_new == '0) || (cg_new > ng);
        idx_nxt       = cg_new - CNTW'(1);
        state_nxt     = ST_SUM;
      end
      ST_SUM: begin
        s_nxt     = {1'b0, 32'(gv)} + SUM_W'(job_v_r);
        state_nxt = err_r ? ST_FIN : ST_SHIFT;
      end
      ST_SHIFT: begin
        // bring the integer to Q16, rounding when scaled down
        if (e[7]) begin
          a_nxt = SHL_W'(rnd >> n);
        end else begin
          a_nxt = SHL_W'(s_r) << e[6:0];
        end
        state_nxt = ST_REF;
      end
      ST_REF: begin
        neg_nxt = sa[SREF_W-1];
        m_nxt   = (mag >= SREF_W'(MAG_CLAMP)) ? MAG_CLAMP : MAG_W'(mag);
        if (dec_mult_r >= DM_ONE) begin
          q_nxt     = {1'b0, m_nxt};
          state_nxt = ST_FIN;
        end else begin
          hp_nxt    = '0;
          lp_nxt    = '0;
          dmsh_nxt  = dec_mult_r[FRAC_W-1:0];
          mcnt_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // one multiplier bit per cycle, product shifts right
        hp_nxt   = {1'b0, psum[Q_W-1:1]};
        lp_nxt   = {psum[0], lp_r[FRAC_W-1:1]};
        dmsh_nxt = dmsh_r >> 1;
        mcnt_nxt = mcnt_r + 5'd1;
        if (mcnt_r == 5'd31) begin
          state_nxt = ST_RND;
        end
      end
      ST_RND: begin
        q_nxt     = hp_r + Q_W'(lp_r[FRAC_W-1]);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_lif_nxt   = job_lif_r;
          out_lir_nxt   = job_lir_r;
          out_err_nxt   = err_r;
          if (err_r) begin
            out_value_nxt = '0;
          end else if (!neg_r) begin
            out_value_nxt = (q_r > Q_W'(OUT_MAX)) ? OUT_MAX : q_r[OUT_W-1:0];
          end else begin
            out_value_nxt = (q_r > Q_W'(OUT_MIN)) ? OUT_MIN : (OUT_W'(0) - q_r[OUT_W-1:0]);
          end
          state_nxt = more_r ? ST_BITS : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sect_r      <= '{phase: PH_BITMAP, cnt: '0, acc: '0, held: '0, cgp1: '0, zf: '1};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sect_r      <= sect_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_count_r  <= '0;
      group_count_r  <= '0;
      first_width_r  <= '0;
      group_width_r  <= '0;
      binary_scale_r <= '0;
      reference_r    <= '0;
      dec_mult_r     <= DM_ONE;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_VALUE_COUNT:  value_count_r  <= cfg_wdata[VC_W-1:0];
        CFG_GROUP_COUNT:  group_count_r  <= cfg_wdata[GC_W-1:0];
        CFG_FIRST_WIDTH:  first_width_r  <= cfg_wdata[WD_W-1:0];
        CFG_GROUP_WIDTH:  group_width_r  <= cfg_wdata[WD_W-1:0];
        CFG_BINARY_SCALE: binary_scale_r <= cfg_wdata[BS_W-1:0];
        CFG_REFERENCE:    reference_r    <= cfg_wdata[REF_W-1:0];
        CFG_DEC_MULT:     dec_mult_r     <= cfg_wdata[DM_W-1:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    bidx_r      <= bidx_nxt;
    job_cnt_r   <= job_cnt_nxt;
    job_v_r     <= job_v_nxt;
    job_lif_r   <= job_lif_nxt;
    job_lir_r   <= job_lir_nxt;
    more_r      <= more_nxt;
    err_r       <= err_nxt;
    idx_r       <= idx_nxt;
    s_r         <= s_nxt;
    a_r         <= a_nxt;
    m_r         <= m_nxt;
    neg_r       <= neg_nxt;
    hp_r        <= hp_nxt;
    lp_r        <= lp_nxt;
    dmsh_r      <= dmsh_nxt;
    mcnt_r      <= mcnt_nxt;
    q_r         <= q_nxt;
    out_value_r <= out_value_nxt;
    out_lif_r   <= out_lif_nxt;
    out_lir_r   <= out_lir_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_value_q16     = $signed(out_value_r);
  assign out_last_in_field = out_lif_r;
  assign out_last_in_run   = out_lir_r;
  assign out_index_error   = out_err_r;

endmodule
`default_nettype wire
